[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/mff_pkg.sv]
// Types, constants and helpers for the mist fog factor block.
// No dependencies; used by every module of the block.
package mff_pkg;

   localparam int FRAC_BITS = 16;
   localparam int FOG_W     = FRAC_BITS + 1;
   localparam int OUT_W     = 17;
   localparam int SR_W      = FRAC_BITS + 4;
   localparam int PROD_W    = FOG_W + OUT_W;
   localparam int HALF_F    = 1 << (FRAC_BITS - 1);

   localparam logic [FOG_W-1:0] ONE_F   = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [OUT_W-1:0] OUT_ONE = 17'h10000;

   localparam logic [1:0] FALL_QUAD = 2'd0;
   localparam logic [1:0] FALL_LIN  = 2'd1;

   // queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // back pipeline stage map
   localparam int ST_DIV_END = FRAC_BITS;
   localparam int ST_SQ0     = ST_DIV_END + 1;
   localparam int ST_SQ_END  = ST_SQ0 + FRAC_BITS;
   localparam int ST_SEL     = ST_SQ_END + 1;
   localparam int ST_HGT     = ST_SEL + 1;
   localparam int ST_VIS     = ST_HGT + 1;
   localparam int ST_LAST    = ST_VIS + 1;

   typedef enum logic [2:0] {
      REG_START,
      REG_DEPTH,
      REG_FALLOFF,
      REG_HEIGHT,
      REG_INTENSITY,
      REG_ROT,
      REG_OFFSET
   } csr_idx_type;

   typedef enum logic [1:0] {FOG_ZERO, FOG_ONE, FOG_FRAC} fog_cls_type;
   typedef enum logic [1:0] {HGT_KEEP, HGT_GONE, HGT_FADE} hgt_cls_type;

   typedef struct packed {
      logic signed [31:0] start;
      logic [30:0]        depth;
      logic [1:0]         falloff;
      logic [30:0]        height;
      logic [16:0]        intensity;
      logic [47:0]        rot;
      logic signed [31:0] offset;
   } cfg_type;

   typedef struct packed {
      fog_cls_type fcls;
      logic [30:0] dnum;
      hgt_cls_type hcls;
      logic [30:0] hrem;
   } entry_type;

   typedef struct packed {
      fog_cls_type          fcls;
      hgt_cls_type          hcls;
      logic [30:0]          drem;
      logic [FRAC_BITS-1:0] dquo;
      logic [30:0]          hrem;
      logic [FRAC_BITS-1:0] hquo;
      logic [FRAC_BITS-1:0] q;
      logic [FOG_W-1:0]     qsq;
      logic [FOG_W-1:0]     rsq;
      logic [SR_W-1:0]      srem;
      logic [FRAC_BITS-1:0] sroot;
      logic [2*FRAC_BITS-1:0] srad;
      logic [FOG_W-1:0]     fog;
      logic [PROD_W-1:0]    prod;
      logic [OUT_W-1:0]     alpha;
   } stage_type;

   // product of two fractions, rounded half up
   function automatic logic [FOG_W-1:0] fmul(input logic [FOG_W-1:0] a,
                                             input logic [FOG_W-1:0] b);
      logic [2*FOG_W-1:0] p;
      p = (2*FOG_W)'(a) * (2*FOG_W)'(b) + (2*FOG_W)'(HALF_F);
      return p[FRAC_BITS+FOG_W-1:FRAC_BITS];
   endfunction

endpackage

[hw/rtl/mff_front.sv]
// Front end: depth offset, height row products, classification of each request.
// Depends on mff_pkg.
module mff_front (
   input  logic              clock,
   input  logic              reset,
   input  mff_pkg::cfg_type  cfg,
   input  logic              req_push,
   output logic              req_full,
   input  logic [31:0]       pixel_depth,
   input  logic [31:0]       point_x,
   input  logic [31:0]       point_y,
   input  logic [31:0]       point_z,
   input  logic              q_full,
   output logic              push,
   output mff_pkg::entry_type push_data
);

   logic fadv;
   logic accept;
   logic f1_vld_ff, f1_vld_in;
   logic f2_vld_ff, f2_vld_in;
   logic signed [32:0] d_ff, d_in;
   logic signed [47:0] prod_ff [3];
   logic signed [47:0] prod_in [3];
   mff_pkg::entry_type ent_ff, ent_in;
   logic signed [51:0] hsum;
   logic signed [51:0] h30s;
   logic signed [51:0] hdiff;

   always_comb begin
      fadv      = !(f2_vld_ff && q_full);
      accept    = req_push && fadv;
      f1_vld_in = fadv ? accept : f1_vld_ff;
      f2_vld_in = fadv ? f1_vld_ff : f2_vld_ff;

      d_in = $signed({pixel_depth[31], pixel_depth}) - $signed({cfg.start[31], cfg.start});
      prod_in[0] = $signed(cfg.rot[15:0]) * $signed(point_x);
      prod_in[1] = $signed(cfg.rot[31:16]) * $signed(point_y);
      prod_in[2] = $signed(cfg.rot[47:32]) * $signed(point_z);

      // world height in Q.30
      hsum = $signed({{4{prod_ff[0][47]}}, prod_ff[0]})
           + $signed({{4{prod_ff[1][47]}}, prod_ff[1]})
           + $signed({{4{prod_ff[2][47]}}, prod_ff[2]})
           + $signed({{6{cfg.offset[31]}}, cfg.offset, 14'b0});
      h30s  = $signed({7'b0, cfg.height, 14'b0});
      hdiff = h30s - hsum;

      if (d_ff <= 33'sd0) begin
         ent_in.fcls = mff_pkg::FOG_ZERO;
      end else if (d_ff >= $signed({2'b00, cfg.depth})) begin
         ent_in.fcls = mff_pkg::FOG_ONE;
      end else begin
         ent_in.fcls = mff_pkg::FOG_FRAC;
      end
      ent_in.dnum = (ent_in.fcls == mff_pkg::FOG_FRAC) ? d_ff[30:0] : 31'd0;

      if (cfg.height == 31'd0) begin
         ent_in.hcls = mff_pkg::HGT_KEEP;
      end else if (hsum > h30s) begin
         ent_in.hcls = mff_pkg::HGT_GONE;
      end else if (hsum > 52'sd0) begin
         ent_in.hcls = mff_pkg::HGT_FADE;
      end else begin
         ent_in.hcls = mff_pkg::HGT_KEEP;
      end
      ent_in.hrem = (ent_in.hcls == mff_pkg::HGT_FADE) ? hdiff[44:14] : 31'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
      end else begin
         f1_vld_ff <= f1_vld_in;
         f2_vld_ff <= f2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fadv) begin
         d_ff    <= d_in;
         prod_ff <= prod_in;
         ent_ff  <= ent_in;
      end
   end

   assign req_full  = !fadv;
   assign push      = f2_vld_ff && !q_full;
   assign push_data = ent_ff;

endmodule

[hw/rtl/mff_queue.sv]
// Short queue of classified requests between front and back.
// Depends on mff_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mff_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mff_pkg::entry_type push_data,
   input  logic               pop,
   output mff_pkg::entry_type head,
   output logic               full,
   output logic               nonempty
);

   mff_pkg::entry_type ent_ff [mff_pkg::QDEPTH];
   logic [mff_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mff_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mff_pkg::QCNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head     = ent_ff[rd_ptr_ff];
   assign full     = (cnt_ff == mff_pkg::QCNT_W'(mff_pkg::QDEPTH));
   assign nonempty = (cnt_ff != '0);

   `ASSERT_ALWAYS(a_push_not_full, clock, reset, !(push && full))
   `ASSERT_ALWAYS(a_pop_not_empty, clock, reset, !(pop && !nonempty))
   `ASSERT_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= mff_pkg::QCNT_W'(mff_pkg::QDEPTH))
   `ASSERT_NEXT(a_cnt_track, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + 1'b1)

endmodule

[hw/rtl/mff_back.sv]
// Back end: fog and height divisions, square root, falloff and final scale.
// Depends on mff_pkg.
module mff_back (
   input  logic               clock,
   input  logic               reset,
   input  mff_pkg::cfg_type   cfg,
   input  logic               q_nonempty,
   input  mff_pkg::entry_type q_head,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [16:0]        rsp_fog_alpha
);

   localparam int F = mff_pkg::FRAC_BITS;

   logic adv;
   logic vld_ff [mff_pkg::ST_LAST+1];
   mff_pkg::stage_type pipe_ff [mff_pkg::ST_LAST+1];
   mff_pkg::stage_type pipe_in [mff_pkg::ST_LAST+1];
   logic [31:0] dt, ht;
   logic [mff_pkg::SR_W-1:0] st, trial;
   logic [mff_pkg::OUT_W-1:0] inten;
   logic [mff_pkg::PROD_W-1:0] rnd;

   assign adv   = !vld_ff[mff_pkg::ST_LAST] || rsp_pop;
   assign q_pop = adv && q_nonempty;

   always_comb begin
      dt    = '0;
      ht    = '0;
      st    = '0;
      trial = '0;
      rnd   = '0;
      inten = (cfg.intensity > mff_pkg::OUT_ONE) ? mff_pkg::OUT_ONE : cfg.intensity;

      pipe_in[0]      = '0;
      pipe_in[0].fcls = q_head.fcls;
      pipe_in[0].hcls = q_head.hcls;
      pipe_in[0].drem = q_head.dnum;
      pipe_in[0].hrem = q_head.hrem;

      for (int k = 1; k <= mff_pkg::ST_LAST; k++) begin
         pipe_in[k] = pipe_ff[k-1];
         if (k <= mff_pkg::ST_DIV_END) begin
            // one quotient bit of each division
            dt = {pipe_ff[k-1].drem, 1'b0};
            if (dt >= {1'b0, cfg.depth}) begin
               dt = dt - {1'b0, cfg.depth};
               pipe_in[k].dquo = {pipe_ff[k-1].dquo[F-2:0], 1'b1};
            end else begin
               pipe_in[k].dquo = {pipe_ff[k-1].dquo[F-2:0], 1'b0};
            end
            pipe_in[k].drem = dt[30:0];
            ht = {pipe_ff[k-1].hrem, 1'b0};
            if (ht >= {1'b0, cfg.height}) begin
               ht = ht - {1'b0, cfg.height};
               pipe_in[k].hquo = {pipe_ff[k-1].hquo[F-2:0], 1'b1};
            end else begin
               pipe_in[k].hquo = {pipe_ff[k-1].hquo[F-2:0], 1'b0};
            end
            pipe_in[k].hrem = ht[30:0];
         end else if (k == mff_pkg::ST_SQ0) begin
            pipe_in[k].q     = pipe_ff[k-1].dquo;
            pipe_in[k].qsq   = mff_pkg::fmul({1'b0, pipe_ff[k-1].dquo},
                                             {1'b0, pipe_ff[k-1].dquo});
            pipe_in[k].rsq   = mff_pkg::fmul({1'b0, pipe_ff[k-1].hquo},
                                             {1'b0, pipe_ff[k-1].hquo});
            pipe_in[k].srad  = {pipe_ff[k-1].dquo, {F{1'b0}}};
            pipe_in[k].srem  = '0;
            pipe_in[k].sroot = '0;
         end else if (k <= mff_pkg::ST_SQ_END) begin
            // one root bit per stage
            st    = {pipe_ff[k-1].srem[mff_pkg::SR_W-3:0], pipe_ff[k-1].srad[2*F-1:2*F-2]};
            trial = mff_pkg::SR_W'({pipe_ff[k-1].sroot, 2'b01});
            if (st >= trial) begin
               pipe_in[k].srem  = st - trial;
               pipe_in[k].sroot = {pipe_ff[k-1].sroot[F-2:0], 1'b1};
            end else begin
               pipe_in[k].srem  = st;
               pipe_in[k].sroot = {pipe_ff[k-1].sroot[F-2:0], 1'b0};
            end
            pipe_in[k].srad = {pipe_ff[k-1].srad[2*F-3:0], 2'b00};
         end else if (k == mff_pkg::ST_SEL) begin
            case (pipe_ff[k-1].fcls)
               mff_pkg::FOG_ZERO: pipe_in[k].fog = '0;
               mff_pkg::FOG_ONE:  pipe_in[k].fog = mff_pkg::ONE_F;
               default: begin
                  if (cfg.falloff == mff_pkg::FALL_QUAD) begin
                     pipe_in[k].fog = pipe_ff[k-1].qsq;
                  end else if (cfg.falloff == mff_pkg::FALL_LIN) begin
                     pipe_in[k].fog = {1'b0, pipe_ff[k-1].q};
                  end else begin
                     pipe_in[k].fog = {1'b0, pipe_ff[k-1].sroot};
                  end
               end
            endcase
         end else if (k == mff_pkg::ST_HGT) begin
            case (pipe_ff[k-1].hcls)
               mff_pkg::HGT_GONE: pipe_in[k].fog = '0;
               mff_pkg::HGT_FADE: pipe_in[k].fog = mff_pkg::fmul(pipe_ff[k-1].fog,
                                                                 pipe_ff[k-1].rsq);
               default:           pipe_in[k].fog = pipe_ff[k-1].fog;
            endcase
         end else if (k == mff_pkg::ST_VIS) begin
            pipe_in[k].prod = mff_pkg::PROD_W'(mff_pkg::ONE_F - pipe_ff[k-1].fog)
                            * mff_pkg::PROD_W'(mff_pkg::OUT_ONE - inten);
         end else begin
            rnd = pipe_ff[k-1].prod + mff_pkg::PROD_W'(mff_pkg::HALF_F);
            pipe_in[k].alpha = rnd[F+mff_pkg::OUT_W-1:F];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= mff_pkg::ST_LAST; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= q_nonempty;
         for (int k = 1; k <= mff_pkg::ST_LAST; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pipe_ff <= pipe_in;
      end
   end

   assign rsp_empty     = !vld_ff[mff_pkg::ST_LAST];
   assign rsp_fog_alpha = pipe_ff[mff_pkg::ST_LAST].alpha;

endmodule

[hw/rtl/mist_fog_factor.sv]
// Top level of the distance fog factor block with height fade.
// Depends on mff_pkg, mff_front, mff_queue and mff_back.
//
// Usage:
//  - Requests enter on req_push / req_full with a pixel's depth and eye-space
//    point; a request is taken on a clock edge with req_push high, req_full low.
//  - Results leave as a queue: while rsp_empty is low, rsp_fog_alpha holds the
//    oldest result; it is taken on an edge with rsp_pop high.
//  - Unknown indexes are ignored. Users write registers via csr_we / csr_idx /
//    csr_wdata only while no request is in flight; the block does not check it.
//  - Throughput: one request per clock while results are popped. The front stage
//    hands classified requests to a four-entry queue; the back pipeline runs one
//    quotient bit of the fog and height divisions per stage, then one root
//    bit per stage, then falloff, height fade and the final scale.
//  - When the consumer stops popping, the back pipeline holds, the queue fills
//    and the front raises req_full; nothing is dropped.
//  - Reset (synchronous, active high) empties the pipeline and queue and
//    restores register defaults (fog depth 1.0, all else zero).
module mist_fog_factor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_pixel_depth,
   input  logic [31:0] req_point_x,
   input  logic [31:0] req_point_y,
   input  logic [31:0] req_point_z,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [16:0] rsp_fog_alpha,
   input  logic        csr_we,
   input  logic [2:0]  csr_idx,
   input  logic [47:0] csr_wdata
);

   mff_pkg::cfg_type   cfg_ff, cfg_in;
   logic               push;
   mff_pkg::entry_type push_data;
   logic               q_full;
   logic               q_pop;
   logic               q_nonempty;
   mff_pkg::entry_type q_head;

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (mff_pkg::csr_idx_type'(csr_idx))
            mff_pkg::REG_START:     cfg_in.start     = $signed(csr_wdata[31:0]);
            mff_pkg::REG_DEPTH:     cfg_in.depth     = csr_wdata[30:0];
            mff_pkg::REG_FALLOFF:   cfg_in.falloff   = csr_wdata[1:0];
            mff_pkg::REG_HEIGHT:    cfg_in.height    = csr_wdata[30:0];
            mff_pkg::REG_INTENSITY: cfg_in.intensity = csr_wdata[16:0];
            mff_pkg::REG_ROT:       cfg_in.rot       = csr_wdata;
            mff_pkg::REG_OFFSET:    cfg_in.offset    = $signed(csr_wdata[31:0]);
            default:                cfg_in           = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // start, depth 1.0, falloff, height, intensity, rot, offset
         cfg_ff <= {32'd0, 31'h10000, 2'd0, 31'd0, 17'd0, 48'd0, 32'd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mff_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_push    (req_push),
      .req_full    (req_full),
      .pixel_depth (req_pixel_depth),
      .point_x     (req_point_x),
      .point_y     (req_point_y),
      .point_z     (req_point_z),
      .q_full      (q_full),
      .push        (push),
      .push_data   (push_data)
   );

   mff_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .nonempty  (q_nonempty)
   );

   mff_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .q_nonempty    (q_nonempty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_fog_alpha (rsp_fog_alpha)
   );

endmodule
